// ===== design/bfe_pkg.sv =====
// Shared types and constants for the byte FIFO with frame extraction.
// No dependencies.
package bfe_pkg;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_GET   = 2'd1;
  localparam logic [1:0] CMD_FRAME = 2'd2;
  localparam logic [1:0] CMD_CLR   = 2'd3;

  localparam logic [7:0] FRAME_HDR = 8'hAB;
  localparam logic [8:0] FILL_SAT  = 9'h1FF;

  // persistent frame parser state
  typedef struct packed {
    logic       in_frame;
    logic       len_seen;
    logic [8:0] remain;
    logic [8:0] ffill;
  } bfe_pst_t;

  // one result item
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       dvld;
    logic       last;
    logic       ok;
    logic [8:0] flen;
    logic       trunc;
  } bfe_res_t;

endpackage

// ===== design/bfe_parse.sv =====
// One step of the frame parser: consumes one byte, updates parser state.
// Depends on bfe_pkg.
module bfe_parse import bfe_pkg::*; (
  input  bfe_pst_t   pst_i,
  input  logic [7:0] byte_i,
  output bfe_pst_t   pst_o,
  output logic [8:0] slot_o,
  output logic       keep_o,
  output logic       done_o
);

  bfe_pst_t   p;
  logic       keep;
  logic       done;

  always_comb begin
    p    = pst_i;
    keep = 1'b0;
    done = 1'b0;
    if (!pst_i.in_frame) begin
      if (byte_i == FRAME_HDR) begin
        p.in_frame = 1'b1;
        p.len_seen = 1'b0;
        p.ffill    = '0;
        p.remain   = '0;
        keep       = 1'b1;
      end
    end else if (!pst_i.len_seen) begin
      p.len_seen = 1'b1;
      p.remain   = {1'b0, byte_i} + 9'd1;
      keep       = 1'b1;
    end else begin
      p.remain = pst_i.remain - 9'd1;
      keep     = 1'b1;
      done     = (p.remain == 9'd0);
    end
    slot_o = p.ffill;
    if (keep && (p.ffill != FILL_SAT)) begin
      p.ffill = p.ffill + 9'd1;
    end
    if (done) begin
      p.in_frame = 1'b0;
      p.len_seen = 1'b0;
    end
    pst_o  = p;
    keep_o = keep;
    done_o = done;
  end

endmodule

// ===== design/bfe_seq.sv =====
// Command sequencer: ring store, frame store, put and clear, get and frame runs.
// Depends on bfe_pkg and bfe_parse.
module bfe_seq import bfe_pkg::*; #(
  parameter int FIFO_DEPTH = 256,
  parameter int FRAME_MAX  = 64,
  parameter int MAX_GET    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] cmd_i,
  input  logic [7:0] byte_i,
  input  logic [6:0] req_i,
  input  logic [8:0] cap_i,
  output logic       busy_o,
  output logic [8:0] fill_o,
  output bfe_res_t   res_o
);

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_GRD   = 7'b0000010,
    S_GEM   = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_PARSE = 7'b0010000,
    S_FRD   = 7'b0100000,
    S_FEM   = 7'b1000000
  } bfe_state_t;

  bfe_state_t     state_r, state_nxt;
  logic [AW-1:0]  rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]  wr_idx_r, wr_idx_nxt;
  logic [8:0]     fill_r, fill_nxt;
  logic [6:0]     cnt_r, cnt_nxt;
  logic [FW-1:0]  fidx_r, fidx_nxt;
  bfe_pst_t       pst_r, pst_nxt;
  bfe_res_t       res_r, res_nxt;

  logic [7:0]     ring_mem [FIFO_DEPTH];
  logic [7:0]     ring_q;
  logic           ring_we;
  logic           ring_re;
  logic [7:0]     frm_mem [FRAME_MAX];
  logic [7:0]     frm_q;
  logic           frm_we;
  logic           frm_re;
  logic [FW-1:0]  frm_waddr;

  bfe_pst_t       pst_step;
  logic [8:0]     slot;
  logic           keep;
  logic           done;

  logic [6:0]     req_cap;
  logic [6:0]     get_n;

  bfe_parse u_parse (
    .pst_i  (pst_r),
    .byte_i (ring_q),
    .pst_o  (pst_step),
    .slot_o (slot),
    .keep_o (keep),
    .done_o (done)
  );

  function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
    return (i == AW'(FIFO_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  always_comb begin
    req_cap = (req_i > 7'(MAX_GET)) ? 7'(MAX_GET) : req_i;
    get_n   = ({2'b00, req_cap} > fill_r) ? fill_r[6:0] : req_cap;
  end

  always_comb begin
    state_nxt  = state_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;
    fill_nxt   = fill_r;
    cnt_nxt    = cnt_r;
    fidx_nxt   = fidx_r;
    pst_nxt    = pst_r;
    res_nxt    = '0;
    ring_we    = 1'b0;
    ring_re    = 1'b0;
    frm_we     = 1'b0;
    frm_re     = 1'b0;
    frm_waddr  = slot[FW-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd_i)
            CMD_PUT: begin
              res_nxt.vld  = 1'b1;
              res_nxt.last = 1'b1;
              if (fill_r < cap_i) begin
                ring_we      = 1'b1;
                wr_idx_nxt   = inc_idx(wr_idx_r);
                fill_nxt     = fill_r + 9'd1;
                res_nxt.ok   = 1'b1;
              end
            end
            CMD_CLR: begin
              fill_nxt     = '0;
              rd_idx_nxt   = wr_idx_r;
              res_nxt.vld  = 1'b1;
              res_nxt.last = 1'b1;
              res_nxt.ok   = 1'b1;
            end
            default: begin
              if (req_i == 7'd0) begin
                res_nxt.vld  = 1'b1;
                res_nxt.last = 1'b1;
              end else if (cmd_i == CMD_GET) begin
                if (get_n == 7'd0) begin
                  res_nxt.vld  = 1'b1;
                  res_nxt.last = 1'b1;
                  res_nxt.ok   = 1'b1;
                end else begin
                  fill_nxt  = fill_r - {2'b00, get_n};
                  cnt_nxt   = get_n;
                  state_nxt = S_GRD;
                end
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_GRD: begin
        ring_re    = 1'b1;
        rd_idx_nxt = inc_idx(rd_idx_r);
        state_nxt  = S_GEM;
      end
      S_GEM: begin
        res_nxt.vld  = 1'b1;
        res_nxt.data = ring_q;
        res_nxt.dvld = 1'b1;
        res_nxt.ok   = 1'b1;
        res_nxt.last = (cnt_r == 7'd1);
        cnt_nxt      = cnt_r - 7'd1;
        state_nxt    = (cnt_r == 7'd1) ? S_IDLE : S_GRD;
      end
      S_SCAN: begin
        if (fill_r == 9'd0) begin
          res_nxt.vld  = 1'b1;
          res_nxt.last = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          ring_re    = 1'b1;
          rd_idx_nxt = inc_idx(rd_idx_r);
          fill_nxt   = fill_r - 9'd1;
          state_nxt  = S_PARSE;
        end
      end
      S_PARSE: begin
        pst_nxt = pst_step;
        frm_we  = keep && (slot < 9'(FRAME_MAX));
        if (done) begin
          cnt_nxt   = (pst_step.ffill > 9'(FRAME_MAX)) ? 7'(FRAME_MAX)
                                                       : pst_step.ffill[6:0];
          fidx_nxt  = '0;
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_FRD: begin
        frm_re    = 1'b1;
        fidx_nxt  = fidx_r + 1'b1;
        state_nxt = S_FEM;
      end
      S_FEM: begin
        res_nxt.vld   = 1'b1;
        res_nxt.data  = frm_q;
        res_nxt.dvld  = 1'b1;
        res_nxt.ok    = 1'b1;
        res_nxt.flen  = pst_r.ffill;
        res_nxt.trunc = (pst_r.ffill > 9'(FRAME_MAX));
        res_nxt.last  = (cnt_r == 7'd1);
        cnt_nxt       = cnt_r - 7'd1;
        state_nxt     = (cnt_r == 7'd1) ? S_IDLE : S_FRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
      fill_r   <= '0;
      cnt_r    <= '0;
      fidx_r   <= '0;
      pst_r    <= '0;
      res_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
      fill_r   <= fill_nxt;
      cnt_r    <= cnt_nxt;
      fidx_r   <= fidx_nxt;
      pst_r    <= pst_nxt;
      res_r    <= res_nxt;
    end
  end

  // ring store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[wr_idx_r] <= byte_i;
    end
    if (ring_re) begin
      ring_q <= ring_mem[rd_idx_r];
    end
  end

  // frame store
  always_ff @(posedge clk) begin
    if (frm_we) begin
      frm_mem[frm_waddr] <= ring_q;
    end
    if (frm_re) begin
      frm_q <= frm_mem[fidx_r];
    end
  end

  assign busy_o = (state_r != S_IDLE);
  assign fill_o = fill_r;
  assign res_o  = res_r;

endmodule

// ===== design/byte_fifo_with_frame_extract.sv =====
// Top level: byte ring FIFO with a persistent frame extractor.
// Depends on bfe_pkg and bfe_seq (which uses bfe_parse).
//
//  channel   handshake            payload
//  input     start & !busy        in_cmd, in_byte, in_req_count
//  result    out_valid (strobe)   out_byte .. out_full_flag
//  config    cfg_valid & ready    cfg_data (capacity)
//
// Put, reset, zero-count get/frame and get on empty: result next cycle. Get: a
// ring read and a result per byte. Frame: a ring read and a parse per byte scanned,
// a frame store read and a result per byte returned, plus a scan step if the FIFO
// runs dry first; reads are registered. Busy stays high for the whole run. Reset is
// synchronous; the stores need no clearing pass. The receiver cannot stall results.
module byte_fifo_with_frame_extract import bfe_pkg::*; #(
  parameter int FIFO_DEPTH = 256,
  parameter int FRAME_MAX  = 64,
  parameter int MAX_GET    = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_byte,
  input  logic [6:0] in_req_count,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_last_of_run,
  output logic       out_op_ok,
  output logic [8:0] out_frame_len,
  output logic       out_frame_truncated,
  output logic [8:0] out_fill_level,
  output logic [8:0] out_room_left,
  output logic       out_empty_flag,
  output logic       out_full_flag,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_data
);

  localparam logic [8:0] CAP_LIM = (FIFO_DEPTH > 511) ? 9'd511 : 9'(FIFO_DEPTH);

  logic [8:0] cap_r;
  logic [8:0] cap_eff;
  logic [8:0] fill;
  bfe_res_t   res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 9'd256;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_data;
    end
  end

  assign cap_eff   = (cap_r > CAP_LIM) ? CAP_LIM : cap_r;
  assign cfg_ready = !busy;

  bfe_seq #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .FRAME_MAX  (FRAME_MAX),
    .MAX_GET    (MAX_GET)
  ) u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd_i  (in_cmd),
    .byte_i (in_byte),
    .req_i  (in_req_count),
    .cap_i  (cap_eff),
    .busy_o (busy),
    .fill_o (fill),
    .res_o  (res)
  );

  assign out_valid           = res.vld;
  assign out_byte            = res.data;
  assign out_byte_valid      = res.dvld;
  assign out_last_of_run     = res.last;
  assign out_op_ok           = res.ok;
  assign out_frame_len       = res.flen;
  assign out_frame_truncated = res.trunc;
  assign out_fill_level      = fill;
  assign out_full_flag       = (fill >= cap_eff);
  assign out_room_left       = out_full_flag ? 9'd0 : (cap_eff - fill);
  assign out_empty_flag      = (fill == 9'd0);

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == CMD_PUT || in_cmd == CMD_CLR))
      |=> (out_valid && out_last_of_run))
    else $error("put/reset item did not give a single result");

  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_byte_valid) |-> out_last_of_run)
    else $error("result without byte is not last of run");

  a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_truncated) |-> (out_frame_len > 9'(FRAME_MAX)))
    else $error("truncated frame with short length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy)
    else $error("busy after reset");

endmodule
